// ===== src/mdg_pkg.sv =====
// Shared types, constants and register map for the dual-gain MCP charge-division block.
// No dependencies; used by every module under src.
package mdg_pkg;

  localparam int ADC_BITS_DEF  = 12;
  localparam int SAT_LEVEL_DEF = 3840;
  localparam int FRAC_BITS_DEF = 15;

  localparam int PED_W      = 12;
  localparam int Q_W        = 12;
  localparam int SUM_W      = 14;
  localparam int OUT_W      = 16;
  localparam int POS_LIMIT  = 32767;
  localparam int NUM_ANODES = 4;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  localparam int ANODE_TL = 0;
  localparam int ANODE_TR = 1;
  localparam int ANODE_BR = 2;
  localparam int ANODE_BL = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PED_HI_TL = 3'd0,
    REG_PED_HI_TR = 3'd1,
    REG_PED_HI_BR = 3'd2,
    REG_PED_HI_BL = 3'd3,
    REG_PED_LO_TL = 3'd4,
    REG_PED_LO_TR = 3'd5,
    REG_PED_LO_BR = 3'd6,
    REG_PED_LO_BL = 3'd7
  } reg_idx_t;

  function automatic logic [PED_W-1:0] ped_reset_val(input reg_idx_t idx);
    logic [PED_W-1:0] v;
    unique case (idx)
      REG_PED_HI_TL: v = 12'd120;
      REG_PED_HI_TR: v = 12'd180;
      REG_PED_HI_BR: v = 12'd300;
      REG_PED_HI_BL: v = 12'd160;
      REG_PED_LO_TL: v = 12'd20;
      REG_PED_LO_TR: v = 12'd20;
      REG_PED_LO_BR: v = 12'd20;
      REG_PED_LO_BL: v = 12'd29;
      default:       v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic           hi_good;
    logic           comb_good;
    logic [Q_W-1:0] qh;
    logic [Q_W-1:0] qc;
  } lane_t;

endpackage

// ===== src/mcp_dual_gain_charge_division.sv =====
// Top level: pedestal registers, four anode lanes, merge stage and four divider pipes.
// Depends on mdg_pkg, mdg_anode_lane and mdg_divider.
// out_strobe comes from a strobe shift register matched to the data path: lane register,
// merge register, divider stages and output register; the result is valid while out_strobe is high.
// Throughput: one request per cycle; busy stays low, fully pipelined divide (one bit/stage).
// Reset (rst_n low, synchronous): pipeline strobes cleared, pedestals to defaults.
module mcp_dual_gain_charge_division #(
  parameter int ADC_BITS         = mdg_pkg::ADC_BITS_DEF,
  parameter int SATURATION_LEVEL = mdg_pkg::SAT_LEVEL_DEF,
  parameter int FRACTION_BITS    = mdg_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ADC_BITS-1:0]           in_hi_tl,
  input  logic [ADC_BITS-1:0]           in_hi_tr,
  input  logic [ADC_BITS-1:0]           in_hi_br,
  input  logic [ADC_BITS-1:0]           in_hi_bl,
  input  logic [ADC_BITS-1:0]           in_lo_tl,
  input  logic [ADC_BITS-1:0]           in_lo_tr,
  input  logic [ADC_BITS-1:0]           in_lo_br,
  input  logic [ADC_BITS-1:0]           in_lo_bl,
  output logic                          out_strobe,
  output logic                          out_hi_valid,
  output logic signed [mdg_pkg::OUT_W-1:0] out_hi_x,
  output logic signed [mdg_pkg::OUT_W-1:0] out_hi_y,
  output logic                          out_comb_valid,
  output logic signed [mdg_pkg::OUT_W-1:0] out_comb_x,
  output logic signed [mdg_pkg::OUT_W-1:0] out_comb_y,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mdg_pkg::PADDR_W-1:0]   paddr,
  input  logic [mdg_pkg::PDATA_W-1:0]   pwdata,
  output logic [mdg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int NA  = mdg_pkg::NUM_ANODES;
  localparam int SW  = mdg_pkg::SUM_W;
  localparam int QW  = mdg_pkg::Q_W;
  localparam int PW  = mdg_pkg::PED_W;
  localparam int OW  = mdg_pkg::OUT_W;
  localparam int VLD = FRACTION_BITS + 3;

  // ---------------- configuration ----------------
  logic [PW-1:0]                   ped_r [mdg_pkg::NUM_REGS];
  logic                            cfg_wr;
  logic [mdg_pkg::REG_IDX_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[mdg_pkg::REG_IDX_W+1:2];
  assign prdata  = mdg_pkg::PDATA_W'(ped_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mdg_pkg::NUM_REGS; i++) begin
        ped_r[i] <= mdg_pkg::ped_reset_val(mdg_pkg::reg_idx_t'(i));
      end
    end else if (cfg_wr) begin
      ped_r[cfg_idx] <= pwdata[PW-1:0];
    end
  end

  // ---------------- request and strobe pipeline ----------------
  logic           accept;
  logic [VLD-1:0] vld_r;
  logic           out_strobe_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= {vld_r[VLD-2:0], accept};
      out_strobe_r <= vld_r[VLD-1];
    end
  end

  // ---------------- anode lanes ----------------
  logic [ADC_BITS-1:0] hi_in [NA];
  logic [ADC_BITS-1:0] lo_in [NA];
  mdg_pkg::lane_t      lane_c [NA];
  mdg_pkg::lane_t      lane_r [NA];

  always_comb begin
    hi_in[mdg_pkg::ANODE_TL] = in_hi_tl;
    hi_in[mdg_pkg::ANODE_TR] = in_hi_tr;
    hi_in[mdg_pkg::ANODE_BR] = in_hi_br;
    hi_in[mdg_pkg::ANODE_BL] = in_hi_bl;
    lo_in[mdg_pkg::ANODE_TL] = in_lo_tl;
    lo_in[mdg_pkg::ANODE_TR] = in_lo_tr;
    lo_in[mdg_pkg::ANODE_BR] = in_lo_br;
    lo_in[mdg_pkg::ANODE_BL] = in_lo_bl;
  end

  for (genvar a = 0; a < NA; a++) begin : g_lane
    mdg_anode_lane #(
      .ADC_BITS         (ADC_BITS),
      .SATURATION_LEVEL (SATURATION_LEVEL)
    ) u_lane (
      .hi     (hi_in[a]),
      .lo     (lo_in[a]),
      .ped_hi (ped_r[a]),
      .ped_lo (ped_r[a + NA]),
      .lane   (lane_c[a])
    );

    always_ff @(posedge clk) begin
      lane_r[a] <= lane_c[a];
    end
  end

  // ---------------- merge stage ----------------
  logic [QW-1:0]        qh [NA];
  logic [QW-1:0]        qc [NA];
  logic signed [SW:0]   hx_num, hy_num, cx_num, cy_num;
  logic [SW-1:0]        hi_sum, comb_sum;
  logic                 hi_ok, comb_ok;

  logic [SW-1:0]        hi_sum_r, comb_sum_r;
  logic [SW-1:0]        hx_mag_r, hy_mag_r, cx_mag_r, cy_mag_r;
  logic                 hx_neg_r, hy_neg_r, cx_neg_r, cy_neg_r;
  logic                 hi_ok_r, comb_ok_r;

  function automatic logic [SW-1:0] mag_of(input logic signed [SW:0] v);
    logic signed [SW:0] m;
    m = v[SW] ? -v : v;
    return m[SW-1:0];
  endfunction

  always_comb begin
    hi_ok   = 1'b1;
    comb_ok = 1'b1;
    for (int a = 0; a < NA; a++) begin
      qh[a]   = lane_r[a].qh;
      qc[a]   = lane_r[a].qc;
      hi_ok   = hi_ok && lane_r[a].hi_good;
      comb_ok = comb_ok && lane_r[a].comb_good;
    end
    hi_sum = SW'(qh[mdg_pkg::ANODE_TL]) + SW'(qh[mdg_pkg::ANODE_TR])
           + SW'(qh[mdg_pkg::ANODE_BR]) + SW'(qh[mdg_pkg::ANODE_BL]);
    comb_sum = SW'(qc[mdg_pkg::ANODE_TL]) + SW'(qc[mdg_pkg::ANODE_TR])
             + SW'(qc[mdg_pkg::ANODE_BR]) + SW'(qc[mdg_pkg::ANODE_BL]);
    hx_num = $signed((SW+1)'(qh[mdg_pkg::ANODE_TR])) + $signed((SW+1)'(qh[mdg_pkg::ANODE_BR]))
           - $signed((SW+1)'(qh[mdg_pkg::ANODE_TL])) - $signed((SW+1)'(qh[mdg_pkg::ANODE_BL]));
    hy_num = $signed((SW+1)'(qh[mdg_pkg::ANODE_TL])) + $signed((SW+1)'(qh[mdg_pkg::ANODE_TR]))
           - $signed((SW+1)'(qh[mdg_pkg::ANODE_BR])) - $signed((SW+1)'(qh[mdg_pkg::ANODE_BL]));
    cx_num = $signed((SW+1)'(qc[mdg_pkg::ANODE_TR])) + $signed((SW+1)'(qc[mdg_pkg::ANODE_BR]))
           - $signed((SW+1)'(qc[mdg_pkg::ANODE_TL])) - $signed((SW+1)'(qc[mdg_pkg::ANODE_BL]));
    cy_num = $signed((SW+1)'(qc[mdg_pkg::ANODE_TL])) + $signed((SW+1)'(qc[mdg_pkg::ANODE_TR]))
           - $signed((SW+1)'(qc[mdg_pkg::ANODE_BR])) - $signed((SW+1)'(qc[mdg_pkg::ANODE_BL]));
  end

  always_ff @(posedge clk) begin
    hi_sum_r   <= hi_sum;
    comb_sum_r <= comb_sum;
    hx_mag_r   <= mag_of(hx_num);
    hy_mag_r   <= mag_of(hy_num);
    cx_mag_r   <= mag_of(cx_num);
    cy_mag_r   <= mag_of(cy_num);
    hx_neg_r   <= hx_num[SW];
    hy_neg_r   <= hy_num[SW];
    cx_neg_r   <= cx_num[SW];
    cy_neg_r   <= cy_num[SW];
    hi_ok_r    <= hi_ok;
    comb_ok_r  <= comb_ok;
  end

  // ---------------- dividers ----------------
  logic [FRACTION_BITS:0] hx_q, hy_q, cx_q, cy_q;
  logic                   hx_neg, hy_neg, cx_neg, cy_neg;
  logic                   hx_ok, hy_ok, cx_ok, cy_ok;

  mdg_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div_hx (
    .clk(clk), .mag_i(hx_mag_r), .den_i(hi_sum_r), .neg_i(hx_neg_r), .ok_i(hi_ok_r),
    .quo_o(hx_q), .neg_o(hx_neg), .ok_o(hx_ok)
  );
  mdg_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div_hy (
    .clk(clk), .mag_i(hy_mag_r), .den_i(hi_sum_r), .neg_i(hy_neg_r), .ok_i(hi_ok_r),
    .quo_o(hy_q), .neg_o(hy_neg), .ok_o(hy_ok)
  );
  mdg_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div_cx (
    .clk(clk), .mag_i(cx_mag_r), .den_i(comb_sum_r), .neg_i(cx_neg_r), .ok_i(comb_ok_r),
    .quo_o(cx_q), .neg_o(cx_neg), .ok_o(cx_ok)
  );
  mdg_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div_cy (
    .clk(clk), .mag_i(cy_mag_r), .den_i(comb_sum_r), .neg_i(cy_neg_r), .ok_i(comb_ok_r),
    .quo_o(cy_q), .neg_o(cy_neg), .ok_o(cy_ok)
  );

  // ---------------- output stage ----------------
  function automatic logic [OW-1:0] fmt_pos(input logic [FRACTION_BITS:0] q,
                                            input logic neg, input logic ok);
    logic [OW-2:0] m;
    logic [OW-1:0] v;
    m = (33'(q) > 33'(mdg_pkg::POS_LIMIT)) ? (OW-1)'(mdg_pkg::POS_LIMIT) : (OW-1)'(q);
    v = {1'b0, m};
    if (!ok) begin
      v = '0;
    end else if (neg) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  logic          out_hi_valid_r, out_comb_valid_r;
  logic [OW-1:0] out_hi_x_r, out_hi_y_r, out_comb_x_r, out_comb_y_r;

  always_ff @(posedge clk) begin
    out_hi_valid_r   <= hx_ok;
    out_comb_valid_r <= cx_ok;
    out_hi_x_r       <= fmt_pos(hx_q, hx_neg, hx_ok);
    out_hi_y_r       <= fmt_pos(hy_q, hy_neg, hy_ok);
    out_comb_x_r     <= fmt_pos(cx_q, cx_neg, cx_ok);
    out_comb_y_r     <= fmt_pos(cy_q, cy_neg, cy_ok);
  end

  assign out_strobe     = out_strobe_r;
  assign out_hi_valid   = out_hi_valid_r;
  assign out_comb_valid = out_comb_valid_r;
  assign out_hi_x       = $signed(out_hi_x_r);
  assign out_hi_y       = $signed(out_hi_y_r);
  assign out_comb_x     = $signed(out_comb_x_r);
  assign out_comb_y     = $signed(out_comb_y_r);

endmodule

// ===== src/mdg_anode_lane.sv =====
// One anode lane: pedestal subtraction and good-reading qualification for both paths.
// Depends on mdg_pkg.
module mdg_anode_lane #(
  parameter int ADC_BITS         = mdg_pkg::ADC_BITS_DEF,
  parameter int SATURATION_LEVEL = mdg_pkg::SAT_LEVEL_DEF
) (
  input  logic [ADC_BITS-1:0]      hi,
  input  logic [ADC_BITS-1:0]      lo,
  input  logic [mdg_pkg::PED_W-1:0] ped_hi,
  input  logic [mdg_pkg::PED_W-1:0] ped_lo,
  output mdg_pkg::lane_t           lane
);

  localparam int CW = (ADC_BITS > mdg_pkg::PED_W) ? ADC_BITS : mdg_pkg::PED_W;

  logic [CW-1:0]             hi_x, lo_x, ph_x, pl_x, sat_x;
  logic                      hi_good, hi_sat, lo_ok, lo_counts;
  logic [mdg_pkg::Q_W-1:0]   qh, ql;
  logic signed [mdg_pkg::PED_W+1:0] thr, ql_s;

  always_comb begin
    hi_x  = CW'(hi);
    lo_x  = CW'(lo);
    ph_x  = CW'(ped_hi);
    pl_x  = CW'(ped_lo);
    sat_x = CW'(SATURATION_LEVEL);

    hi_good = (hi_x > ph_x) && (hi_x < sat_x);
    hi_sat  = (hi_x >= sat_x);
    lo_ok   = (lo_x > pl_x) && (lo_x < sat_x);

    qh = mdg_pkg::Q_W'(hi_x - ph_x);
    ql = mdg_pkg::Q_W'(lo_x - pl_x);

    // low-gain value must exceed saturation minus high pedestal (signed)
    thr  = $signed({2'b00, mdg_pkg::PED_W'(SATURATION_LEVEL)}) - $signed({2'b00, ped_hi});
    ql_s = $signed({2'b00, ql});
    lo_counts = ql_s > thr;

    lane.hi_good   = hi_good;
    lane.comb_good = hi_good || (hi_sat && lo_ok && lo_counts);
    lane.qh        = qh;
    lane.qc        = hi_good ? qh : ql;
  end

endmodule

// ===== src/mdg_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, magnitude << FRAC_BITS / sum.
// Depends on mdg_pkg.
module mdg_divider #(
  parameter int FRACTION_BITS = mdg_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic [mdg_pkg::SUM_W-1:0]  mag_i,
  input  logic [mdg_pkg::SUM_W-1:0]  den_i,
  input  logic                       neg_i,
  input  logic                       ok_i,
  output logic [FRACTION_BITS:0]     quo_o,
  output logic                       neg_o,
  output logic                       ok_o
);

  localparam int ST = FRACTION_BITS + 1;
  localparam int SW = mdg_pkg::SUM_W;

  logic [SW-1:0] rem_r [ST];
  logic [SW-1:0] den_r [ST];
  logic [ST-1:0] quo_r [ST];
  logic [ST-1:0] neg_r;
  logic [ST-1:0] ok_r;

  for (genvar s = 0; s < ST; s++) begin : g_stage
    logic [SW:0]   trial, diff;
    logic          take;
    logic [SW-1:0] den_in;
    logic [ST-1:0] quo_in;
    logic          neg_in, ok_in;

    if (s == 0) begin : g_first
      assign trial  = {1'b0, mag_i};
      assign den_in = den_i;
      assign quo_in = '0;
      assign neg_in = neg_i;
      assign ok_in  = ok_i;
    end else begin : g_next
      assign trial  = {rem_r[s-1], 1'b0};
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign neg_in = neg_r[s-1];
      assign ok_in  = ok_r[s-1];
    end

    assign take = trial >= {1'b0, den_in};
    assign diff = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[s] <= take ? diff[SW-1:0] : trial[SW-1:0];
      den_r[s] <= den_in;
      quo_r[s] <= {quo_in[ST-2:0], take};
      neg_r[s] <= neg_in;
      ok_r[s]  <= ok_in;
    end
  end

  assign quo_o = quo_r[ST-1];
  assign neg_o = neg_r[ST-1];
  assign ok_o  = ok_r[ST-1];

endmodule

// ===== test/tb_mcp_dual_gain_charge_division.sv =====
// Testbench for mcp_dual_gain_charge_division: directed and random charge events under several
// pedestal settings, each result checked against an independent position predictor.
// Depends on mdg_pkg and the RTL under src; self-checking, no external files.
module tb_mcp_dual_gain_charge_division;
  timeunit 1ns;
  timeprecision 1ps;
  import mdg_pkg::*;

  localparam int SAT         = SAT_LEVEL_DEF;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int ADC_MAX     = (1 << ADC_BITS_DEF) - 1;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = FRAC + 12;

  typedef struct packed {
    logic [NUM_ANODES-1:0][ADC_BITS_DEF-1:0] hi;
    logic [NUM_ANODES-1:0][ADC_BITS_DEF-1:0] lo;
  } charge_event_t;

  typedef struct packed {
    logic                    hi_valid;
    logic signed [OUT_W-1:0] hi_x;
    logic signed [OUT_W-1:0] hi_y;
    logic                    comb_valid;
    logic signed [OUT_W-1:0] comb_x;
    logic signed [OUT_W-1:0] comb_y;
  } position_t;

  typedef logic [NUM_REGS-1:0][PED_W-1:0] ped_set_t;

  class position_scoreboard;
    logic [PED_W-1:0] ped [NUM_REGS];
    position_t        expected_q [$];
    int unsigned      errors;

    function new();
      ped = '{12'd120, 12'd180, 12'd300, 12'd160, 12'd20, 12'd20, 12'd20, 12'd29};
      errors = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [PDATA_W-1:0] data);
      if (idx < NUM_REGS) ped[idx] = data[PED_W-1:0];
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%0t ERROR %s", $time, msg);
    endfunction

    function string show(position_t p);
      return $sformatf("hi(v=%0b x=%0d y=%0d) comb(v=%0b x=%0d y=%0d)",
                       p.hi_valid, $signed(p.hi_x), $signed(p.hi_y),
                       p.comb_valid, $signed(p.comb_x), $signed(p.comb_y));
    endfunction

    // Q1.15 ratio, magnitude divided and truncated toward zero
    function logic signed [OUT_W-1:0] ratio_q15(int num, int den);
      longint                  mag;
      longint                  quo;
      logic signed [OUT_W-1:0] r;
      if (den <= 0) return '0;
      mag = (num < 0) ? -longint'(num) : longint'(num);
      quo = (mag << FRAC) / den;
      if (quo > POS_LIMIT) quo = POS_LIMIT;
      r = quo[OUT_W-1:0];
      return (num < 0) ? -r : r;
    endfunction

    function void divide(int q [NUM_ANODES], output logic signed [OUT_W-1:0] x,
                         output logic signed [OUT_W-1:0] y);
      int sum;
      sum = q[ANODE_TL] + q[ANODE_TR] + q[ANODE_BR] + q[ANODE_BL];
      x = ratio_q15(q[ANODE_TR] + q[ANODE_BR] - q[ANODE_TL] - q[ANODE_BL], sum);
      y = ratio_q15(q[ANODE_TL] + q[ANODE_TR] - q[ANODE_BR] - q[ANODE_BL], sum);
    endfunction

    function position_t predict(charge_event_t ev);
      int        qh [NUM_ANODES];
      int        qc [NUM_ANODES];
      int        nh, nc, h, l, ph, pl;
      position_t r;
      r  = '0;
      nh = 0;
      nc = 0;
      for (int i = 0; i < NUM_ANODES; i++) begin
        h  = ev.hi[i];
        l  = ev.lo[i];
        ph = ped[i];
        pl = ped[NUM_ANODES + i];
        qh[i] = 0;
        qc[i] = 0;
        if (h > ph && h < SAT) begin
          qh[i] = h - ph;
          qc[i] = qh[i];
          nh++;
          nc++;
        end else if (h >= SAT && l > pl && l < SAT) begin
          qc[i] = l - pl;
          if (qc[i] > SAT - ph) nc++;
        end
      end
      if (nh == NUM_ANODES) begin
        r.hi_valid = 1'b1;
        divide(qh, r.hi_x, r.hi_y);
      end
      if (nc == NUM_ANODES) begin
        r.comb_valid = 1'b1;
        divide(qc, r.comb_x, r.comb_y);
      end
      return r;
    endfunction

    function void note_request(charge_event_t ev);
      expected_q.push_back(predict(ev));
    endfunction

    function void check_result(position_t got);
      position_t want;
      if (expected_q.size() == 0) begin
        fail($sformatf("result with no request outstanding: %s", show(got)));
        return;
      end
      want = expected_q.pop_front();
      if (got.hi_valid !== want.hi_valid || got.hi_x !== want.hi_x ||
          got.hi_y !== want.hi_y || got.comb_valid !== want.comb_valid ||
          got.comb_x !== want.comb_x || got.comb_y !== want.comb_y)
        fail($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
    endfunction
  endclass

  logic                    clk   = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ADC_BITS_DEF-1:0] in_hi_tl = '0, in_hi_tr = '0, in_hi_br = '0, in_hi_bl = '0;
  logic [ADC_BITS_DEF-1:0] in_lo_tl = '0, in_lo_tr = '0, in_lo_br = '0, in_lo_bl = '0;
  logic                    out_strobe, out_hi_valid, out_comb_valid;
  logic signed [OUT_W-1:0] out_hi_x, out_hi_y, out_comb_x, out_comb_y;
  logic                    psel    = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite  = 1'b0;
  logic [PADDR_W-1:0]      paddr   = '0;
  logic [PDATA_W-1:0]      pwdata  = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  position_scoreboard scoreboard = new();
  int unsigned        quiet_cycles = 0;

  mcp_dual_gain_charge_division dut (
    .clk, .rst_n, .start, .busy,
    .in_hi_tl, .in_hi_tr, .in_hi_br, .in_hi_bl,
    .in_lo_tl, .in_lo_tr, .in_lo_br, .in_lo_bl,
    .out_strobe, .out_hi_valid, .out_hi_x, .out_hi_y,
    .out_comb_valid, .out_comb_x, .out_comb_y,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // monitor: requests, results and register writes, plus the stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1)
        scoreboard.check_result(position_t'{out_hi_valid, out_hi_x, out_hi_y,
                                            out_comb_valid, out_comb_x, out_comb_y});
      if (start === 1'b1 && busy === 1'b0)
        scoreboard.note_request(charge_event_t'{hi: {in_hi_bl, in_hi_br, in_hi_tr, in_hi_tl},
                                                lo: {in_lo_bl, in_lo_br, in_lo_tr, in_lo_tl}});
      if (psel && penable && pwrite && pready === 1'b1)
        scoreboard.write_reg(paddr >> 2, pwdata);
      if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1 ||
          (psel && penable && pready === 1'b1))
        quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_mcp_dual_gain_charge_division: FAIL");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic charge_event_t charge_event(int htl, int htr, int hbr, int hbl,
                                                 int ltl, int ltr, int lbr, int lbl);
    charge_event_t ev;
    ev.hi[ANODE_TL] = htl[11:0];
    ev.hi[ANODE_TR] = htr[11:0];
    ev.hi[ANODE_BR] = hbr[11:0];
    ev.hi[ANODE_BL] = hbl[11:0];
    ev.lo[ANODE_TL] = ltl[11:0];
    ev.lo[ANODE_TR] = ltr[11:0];
    ev.lo[ANODE_BR] = lbr[11:0];
    ev.lo[ANODE_BL] = lbl[11:0];
    return ev;
  endfunction

  function automatic ped_set_t peds(int htl, int htr, int hbr, int hbl,
                                    int ltl, int ltr, int lbr, int lbl);
    return {12'(lbl), 12'(lbr), 12'(ltr), 12'(ltl), 12'(hbl), 12'(hbr), 12'(htr), 12'(htl)};
  endfunction

  // mostly well-formed events against the current pedestals, the rest noise
  function automatic charge_event_t random_event();
    charge_event_t ev;
    bit            formed;
    int            ph, pl, lo_min, hi_top, pick;
    formed = ($urandom_range(9, 0) < 7);
    for (int i = 0; i < NUM_ANODES; i++) begin
      ph     = scoreboard.ped[i];
      pl     = scoreboard.ped[NUM_ANODES + i];
      lo_min = (SAT - ph > 0) ? pl + SAT - ph + 1 : pl + 1;
      pick   = $urandom_range(99, 0);
      ev.hi[i] = 12'($urandom_range(ADC_MAX, 0));
      ev.lo[i] = 12'($urandom_range(ADC_MAX, 0));
      if (formed) begin
        if (pick < 60 && ph + 1 < SAT) begin
          hi_top   = (pick < 12 && ph + 16 < SAT - 1) ? ph + 16 : SAT - 1;
          ev.hi[i] = 12'($urandom_range(hi_top, ph + 1));
        end else if (pick < 85 && lo_min < SAT) begin
          ev.hi[i] = 12'($urandom_range(ADC_MAX, SAT));
          ev.lo[i] = 12'($urandom_range(SAT - 1, lo_min));
        end else if (pick < 92) begin
          ev.hi[i] = 12'($urandom_range(ADC_MAX, SAT));
        end
      end
    end
    return ev;
  endfunction

  task automatic send_event(charge_event_t ev);
    start    <= 1'b1;
    in_hi_tl <= ev.hi[ANODE_TL];
    in_hi_tr <= ev.hi[ANODE_TR];
    in_hi_br <= ev.hi[ANODE_BR];
    in_hi_bl <= ev.hi[ANODE_BL];
    in_lo_tl <= ev.lo[ANODE_TL];
    in_lo_tr <= ev.lo[ANODE_TR];
    in_lo_br <= ev.lo[ANODE_BR];
    in_lo_bl <= ev.lo[ANODE_BL];
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause_requests(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (scoreboard.expected_q.size() != 0) @(posedge clk);
  endtask

  // may leave start high after the last event; a later wait_drained drops it
  task automatic run_random(int n);
    int left, burst, mode;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(30, 1);
      if (burst > left) burst = left;
      repeat (burst) send_event(random_event());
      left -= burst;
      mode = $urandom_range(9, 0);
      if (mode == 0) wait_drained();
      else if (mode < 7) pause_requests($urandom_range(12, 1));
    end
  endtask

  task automatic apb_write(reg_idx_t idx, logic [PED_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() << PED_W) | PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
  endtask

  task automatic apb_read(reg_idx_t idx, output logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
  endtask

  task automatic program_peds(ped_set_t vals);
    logic [PDATA_W-1:0] rd;
    wait_drained();
    for (int i = 0; i < NUM_REGS; i++) apb_write(reg_idx_t'(i), vals[i]);
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_read(reg_idx_t'(i), rd);
      if (rd !== PDATA_W'(vals[i]))
        scoreboard.fail($sformatf("readback of register %0d: expected %0d, got %0d",
                                  i, vals[i], rd));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    ped_set_t p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pedestals: hi {120,180,300,160}, lo {20,20,20,29}
    send_event(charge_event(0, 0, 0, 0, 0, 0, 0, 0));
    send_event(charge_event(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    send_event(charge_event(3839, 3839, 3839, 3839, 0, 0, 0, 0));
    send_event(charge_event(121, 181, 301, 161, 4095, 0, 4095, 0));
    send_event(charge_event(120, 180, 300, 160, 3000, 3000, 3000, 3000));
    send_event(charge_event(2000, 2000, 2000, 2000, 4095, 4095, 4095, 4095));
    send_event(charge_event(3800, 200, 320, 3800, 0, 0, 0, 0));
    send_event(charge_event(121, 3839, 3839, 161, 0, 0, 0, 0));
    send_event(charge_event(3800, 3800, 301, 161, 0, 0, 0, 0));
    send_event(charge_event(3840, 2000, 2000, 2000, 3800, 0, 0, 0));
    send_event(charge_event(3840, 2000, 2000, 2000, 1000, 0, 0, 0));
    send_event(charge_event(3840, 2000, 2000, 2000, 3840, 0, 0, 0));
    send_event(charge_event(3840, 2000, 2000, 2000, 20, 0, 0, 0));
    send_event(charge_event(3840, 2000, 2000, 2000, 3740, 0, 0, 0));
    send_event(charge_event(3840, 2000, 2000, 2000, 3741, 0, 0, 0));
    send_event(charge_event(4095, 4095, 4095, 4095, 3839, 3839, 3839, 3839));
    send_event(charge_event(4095, 3840, 4095, 3840, 3800, 3761, 3641, 3810));
    send_event(charge_event('haaa, 'h555, 'haaa, 'h555, 'h555, 'haaa, 'h555, 'haaa));
    send_event(charge_event('h555, 'haaa, 'h555, 'haaa, 'haaa, 'h555, 'haaa, 'h555));
    pause_requests(5);
    run_random(200);

    program_peds('0);
    run_random(150);

    program_peds('1);
    run_random(100);

    // high pedestals above saturation: any in-range low reading counts
    program_peds(peds(4095, 3900, 3841, 4000, 0, 5, 1, 12));
    send_event(charge_event(3840, 3840, 3840, 3840, 1, 6, 2, 13));
    send_event(charge_event(4095, 4095, 4095, 4095, 3839, 3839, 3839, 3839));
    run_random(200);

    repeat (3) begin
      for (int i = 0; i < NUM_REGS; i++)
        p[i] = (i < NUM_ANODES) ? 12'($urandom_range(2000, 0)) : 12'($urandom_range(400, 0));
      program_peds(p);
      run_random(220);
    end

    for (int i = 0; i < NUM_REGS; i++) p[i] = 12'($urandom_range(ADC_MAX, 0));
    program_peds(p);
    run_random(150);

    program_peds(peds(120, 180, 300, 160, 20, 20, 20, 29));
    run_random(100);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (scoreboard.expected_q.size() != 0)
      scoreboard.fail($sformatf("%0d results never arrived", scoreboard.expected_q.size()));
    if (scoreboard.errors == 0)
      $display("tb_mcp_dual_gain_charge_division: PASS");
    else
      $display("tb_mcp_dual_gain_charge_division: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
src/mdg_pkg.sv
src/mdg_anode_lane.sv
src/mdg_divider.sv
src/mcp_dual_gain_charge_division.sv
test/tb_mcp_dual_gain_charge_division.sv
